FILE: src/hrn_pkg.sv
// ----------------------------------------------------------------------------
// hrn_pkg
// Types and constants shared by the Harris response / NMS block.
// ----------------------------------------------------------------------------
package hrn_pkg;

  localparam int RESP_W  = 48;
  localparam int THR_W   = 47;
  localparam int PROD_W  = 66;
  localparam int OPND_W  = 33;
  localparam int ACC_W   = 136;
  localparam int X_W     = 128;
  localparam int SHAMT_W = 7;
  localparam int CLAMP_W = 14;
  localparam int CFG_W   = 47;
  localparam int IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_LINES = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE       = 3'd2;
  localparam logic [IDX_W-1:0] REG_K           = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd4;

  // multiplier operand selection
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_XXYY = 3'd1;
  localparam logic [2:0] MUL_MAG  = 3'd2;
  localparam logic [2:0] MUL_SUM  = 3'd3;
  localparam logic [2:0] MUL_KLO  = 3'd4;
  localparam logic [2:0] MUL_KHI  = 3'd5;
  localparam logic [2:0] MUL_SX   = 3'd6;

  // accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // operand register operations
  localparam logic [1:0] XOP_NONE = 2'd0;
  localparam logic [1:0] XOP_ABS  = 2'd1;
  localparam logic [1:0] XOP_COPY = 2'd2;

  typedef struct packed {
    logic               load;
    logic [2:0]         mul_sel;
    logic [1:0]         chunk;
    logic [1:0]         acc_op;
    logic [SHAMT_W-1:0] shamt;
    logic [1:0]         x_op;
    logic               round;
    logic               commit;
    logic               emit;
  } hrn_cmd_t;

  typedef struct packed {
    logic out_busy;
  } hrn_status_t;

endpackage

FILE: src/hrn_ctrl.sv
// ----------------------------------------------------------------------------
// hrn_ctrl
// Sequencer that steps the datapath through one pixel's computation.
// ----------------------------------------------------------------------------
module hrn_ctrl
  import hrn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hrn_status_t status,
  output hrn_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [4:0] STEP_LAST = 5'd19;

  logic       state;
  logic       state_next;
  logic [4:0] step;
  logic [4:0] step_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    if (state == ST_IDLE) begin
      if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = ST_RUN;
        step_next  = '0;
      end
    end else begin
      step_next = step + 5'd1;
      unique case (step)
        5'd0: cmd.mul_sel = MUL_XXYY;
        5'd1: begin
          cmd.mul_sel = MUL_MAG;
          cmd.acc_op  = ACC_LOAD;
          cmd.shamt   = 7'd16;
        end
        5'd2: begin
          cmd.mul_sel = MUL_SUM;
          cmd.acc_op  = ACC_SUB;
          cmd.shamt   = 7'd16;
        end
        5'd3: cmd.mul_sel = MUL_KLO;
        5'd4: begin
          cmd.mul_sel = MUL_KHI;
          cmd.acc_op  = ACC_SUB;
        end
        5'd5: begin
          cmd.acc_op = ACC_SUB;
          cmd.shamt  = 7'd33;
        end
        5'd6: cmd.x_op = XOP_ABS;
        5'd7: cmd.mul_sel = MUL_SX;
        5'd8: begin
          cmd.mul_sel = MUL_SX;
          cmd.chunk   = 2'd1;
          cmd.acc_op  = ACC_ADD;
        end
        5'd9: begin
          cmd.mul_sel = MUL_SX;
          cmd.chunk   = 2'd2;
          cmd.acc_op  = ACC_ADD;
          cmd.shamt   = 7'd32;
        end
        5'd10: begin
          cmd.acc_op = ACC_ADD;
          cmd.shamt  = 7'd64;
        end
        5'd11: cmd.x_op = XOP_COPY;
        5'd12: cmd.mul_sel = MUL_SX;
        5'd13: begin
          cmd.mul_sel = MUL_SX;
          cmd.chunk   = 2'd1;
          cmd.acc_op  = ACC_ADD;
        end
        5'd14: begin
          cmd.mul_sel = MUL_SX;
          cmd.chunk   = 2'd2;
          cmd.acc_op  = ACC_ADD;
          cmd.shamt   = 7'd32;
        end
        5'd15: begin
          cmd.mul_sel = MUL_SX;
          cmd.chunk   = 2'd3;
          cmd.acc_op  = ACC_ADD;
          cmd.shamt   = 7'd64;
        end
        5'd16: begin
          cmd.acc_op = ACC_ADD;
          cmd.shamt  = 7'd96;
        end
        5'd17: cmd.round  = 1'b1;
        5'd18: cmd.commit = 1'b1;
        STEP_LAST: begin
          // hold until the output register frees up
          step_next = step;
          if (!status.out_busy) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: src/hrn_datapath.sv
// ----------------------------------------------------------------------------
// hrn_datapath
// Shared multiplier, wide accumulator, line stores, 3x3 window and output.
// ----------------------------------------------------------------------------
module hrn_datapath
  import hrn_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int MAX_LINES      = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hrn_cmd_t                           cmd,
  output hrn_status_t                        status,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0]  lw_m1,
  input  logic [$clog2(MAX_LINES)-1:0]       fl_m1,
  input  logic [23:0]                        scale,
  input  logic [15:0]                        k_coef,
  input  logic [THR_W-1:0]                   threshold,
  input  logic [31:0]                        tensor_xx,
  input  logic signed [31:0]                 tensor_xy,
  input  logic [31:0]                        tensor_yy,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [RESP_W-1:0]           pixel_response,
  output logic [10:0]                        center_x,
  output logic [10:0]                        center_y,
  output logic                               center_valid,
  output logic                               center_is_corner,
  output logic [THR_W-1:0]                   frame_max,
  output logic                               frame_last
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int LW = $clog2(MAX_LINES);

  // operands
  logic [31:0]         xx_r, yy_r, mag_r;
  logic [OPND_W-1:0]   sum_r;
  logic [OPND_W-1:0]   hi_r;
  logic [OPND_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]    term;
  logic [X_W-1:0]      xop;
  logic                sgn;
  logic [31:0]         x_chunk;

  // position and frame state
  logic [CW-1:0] col, x_r, x_cur;
  logic [LW-1:0] line, y_r, y_cur;
  logic [THR_W-1:0] running_max, rm_new, fmax_r;
  logic last_r;

  // line stores and window
  logic signed [RESP_W-1:0] bank0 [MAX_LINE_WIDTH];
  logic signed [RESP_W-1:0] bank1 [MAX_LINE_WIDTH];
  logic signed [RESP_W-1:0] rd0, rd1;
  logic signed [RESP_W-1:0] win [3][3];
  logic signed [RESP_W-1:0] resp, resp_r, top, mid, ctr;
  logic resp_ok, corner, judged;
  logic [CW-1:0] xm1;
  logic [LW-1:0] ym1;

  assign x_cur = frame_start ? '0 : col;
  assign y_cur = frame_start ? '0 : line;

  always_comb begin
    unique case (cmd.chunk)
      2'd0: x_chunk = xop[31:0];
      2'd1: x_chunk = xop[63:32];
      2'd2: x_chunk = xop[95:64];
      2'd3: x_chunk = xop[127:96];
      default: x_chunk = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_XXYY: begin
        mul_a = {1'b0, xx_r};
        mul_b = {1'b0, yy_r};
      end
      MUL_MAG: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, mag_r};
      end
      MUL_SUM: begin
        mul_a = sum_r;
        mul_b = sum_r;
      end
      MUL_KLO: begin
        mul_a = OPND_W'(k_coef);
        mul_b = prod[OPND_W-1:0];
      end
      MUL_KHI: begin
        mul_a = OPND_W'(k_coef);
        mul_b = hi_r;
      end
      MUL_SX: begin
        mul_a = OPND_W'(scale);
        mul_b = {1'b0, x_chunk};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign term = ACC_W'(prod) << cmd.shamt;

  // round to Q.8 and saturate to 48 bits
  assign resp_ok = (&acc[ACC_W-1:103]) | ~(|acc[ACC_W-1:103]);
  always_comb begin
    if (resp_ok) begin
      resp = acc[103:56];
    end else if (acc[ACC_W-1]) begin
      resp = {1'b1, {(RESP_W-1){1'b0}}};
    end else begin
      resp = {1'b0, {(RESP_W-1){1'b1}}};
    end
  end

  assign top = y_r[0] ? rd1 : rd0;
  assign mid = y_r[0] ? rd0 : rd1;
  assign rm_new = (!resp[RESP_W-1] && (resp[THR_W-1:0] > running_max)) ?
                  resp[THR_W-1:0] : running_max;

  // judge the center against threshold and its eight neighbors
  assign ctr = win[1][1];
  always_comb begin
    corner = (ctr > $signed({1'b0, threshold}));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r != 1 || c != 1) && (win[r][c] >= ctr)) begin
          corner = 1'b0;
        end
      end
    end
  end
  assign judged = (x_r >= CW'(2)) && (y_r >= LW'(2));
  assign xm1 = x_r - CW'(1);
  assign ym1 = y_r - LW'(1);

  // arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xx_r  <= tensor_xx;
      yy_r  <= tensor_yy;
      mag_r <= tensor_xy[31] ? 32'(-tensor_xy) : tensor_xy;
      sum_r <= {1'b0, tensor_xx} + {1'b0, tensor_yy};
    end
    prod <= mul_a * mul_b;
    if (cmd.mul_sel == MUL_KLO) begin
      hi_r <= prod[PROD_W-1:OPND_W];
    end
    if (cmd.x_op == XOP_ABS) begin
      xop <= acc[ACC_W-1] ? X_W'(-acc) : X_W'(acc);
      sgn <= acc[ACC_W-1];
      acc <= '0;
    end else if (cmd.x_op == XOP_COPY) begin
      xop <= X_W'(acc);
      acc <= '0;
    end else if (cmd.round) begin
      // negate and add the rounding half in one carry chain
      acc <= sgn ? (~acc + $signed(ACC_W'(56'h80000000000001)))
                 : (acc + $signed(ACC_W'(56'h80000000000000)));
    end else begin
      unique case (cmd.acc_op)
        ACC_LOAD: acc <= $signed(term);
        ACC_ADD:  acc <= acc + $signed(term);
        ACC_SUB:  acc <= acc - $signed(term);
        default:  acc <= acc;
      endcase
    end
  end

  // line stores: read at transfer, write back at commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd0 <= bank0[x_cur];
    end
    if (cmd.commit && !y_r[0]) begin
      bank0[x_r] <= resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd1 <= bank1[x_cur];
    end
    if (cmd.commit && y_r[0]) begin
      bank1[x_r] <= resp;
    end
  end

  // window shift and capture at commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= resp;
      resp_r    <= resp;
      fmax_r    <= rm_new;
      last_r    <= (x_r >= lw_m1) && (y_r >= fl_m1);
    end
    if (cmd.load) begin
      x_r <= x_cur;
      y_r <= y_cur;
    end
  end

  // counters and frame maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      line        <= '0;
      running_max <= '0;
    end else if (cmd.load && frame_start) begin
      col         <= '0;
      line        <= '0;
      running_max <= '0;
    end else if (cmd.commit) begin
      if (x_r >= lw_m1) begin
        col <= '0;
        if (y_r >= fl_m1) begin
          line        <= '0;
          running_max <= '0;
        end else begin
          line        <= y_r + LW'(1);
          running_max <= rm_new;
        end
      end else begin
        col         <= x_r + CW'(1);
        running_max <= rm_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_response   <= resp_r;
      center_x         <= judged ? 11'(xm1) : '0;
      center_y         <= judged ? 11'(ym1) : '0;
      center_valid     <= judged;
      center_is_corner <= judged && corner;
      frame_max        <= fmax_r;
      frame_last       <= last_r;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: src/harris_response_nms.sv
// ----------------------------------------------------------------------------
// harris_response_nms
// Each input transfer runs a 20-step sequence that puts all products through
//   one shared 33x33 multiplier, then its result enters the output register,
//   later while a waiting result is not taken. A new pixel is accepted only
//   in the idle state, once the previous pixel's sequence has finished.
// Reset: synchronous, active high; clears the sequencer, counters, frame
//   maximum and output valid, and loads the configuration defaults.
// Harris response per pixel, two line stores, 3x3 non-maximum suppression.
// ----------------------------------------------------------------------------
module harris_response_nms
  import hrn_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int MAX_LINES      = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              tensor_xx,
  input  logic signed [31:0]       tensor_xy,
  input  logic [31:0]              tensor_yy,
  input  logic                     frame_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RESP_W-1:0] pixel_response,
  output logic [10:0]              center_x,
  output logic [10:0]              center_y,
  output logic                     center_valid,
  output logic                     center_is_corner,
  output logic [THR_W-1:0]         frame_max,
  output logic                     frame_last
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int LW = $clog2(MAX_LINES);
  localparam logic [CLAMP_W-1:0] LW_MAX = CLAMP_W'(MAX_LINE_WIDTH);
  localparam logic [CLAMP_W-1:0] FL_MAX = CLAMP_W'(MAX_LINES);
  localparam logic [CLAMP_W-1:0] DIM_MIN = CLAMP_W'(3);

  // configuration registers
  logic [11:0]      line_width;
  logic [11:0]      frame_lines;
  logic [23:0]      scale_factor;
  logic [15:0]      k_coefficient;
  logic [THR_W-1:0] corner_threshold;

  logic [CLAMP_W-1:0] lw_ext, fl_ext, lw_c, fl_c;
  logic [CW-1:0]      lw_m1;
  logic [LW-1:0]      fl_m1;

  hrn_cmd_t    cmd;
  hrn_status_t status;

  // register writes act at once; user writes only while idle, not checked
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width       <= 12'd640;
      frame_lines      <= 12'd480;
      scale_factor     <= 24'd72253;
      k_coefficient    <= 16'd3932;
      corner_threshold <= 47'd384000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:  line_width       <= cfg_data[11:0];
        REG_FRAME_LINES: frame_lines      <= cfg_data[11:0];
        REG_SCALE:       scale_factor     <= cfg_data[23:0];
        REG_K:           k_coefficient    <= cfg_data[15:0];
        REG_THRESHOLD:   corner_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the frame geometry into 3..MAX and hand over the last index
  assign lw_ext = CLAMP_W'(line_width);
  assign fl_ext = CLAMP_W'(frame_lines);

  always_comb begin
    if (lw_ext < DIM_MIN) begin
      lw_c = DIM_MIN;
    end else if (lw_ext > LW_MAX) begin
      lw_c = LW_MAX;
    end else begin
      lw_c = lw_ext;
    end
    if (fl_ext < DIM_MIN) begin
      fl_c = DIM_MIN;
    end else if (fl_ext > FL_MAX) begin
      fl_c = FL_MAX;
    end else begin
      fl_c = fl_ext;
    end
  end

  assign lw_m1 = CW'(lw_c - CLAMP_W'(1));
  assign fl_m1 = LW'(fl_c - CLAMP_W'(1));

  // sequencer: one transfer starts a pass through all steps
  hrn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, line stores, window and output register
  hrn_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_LINES      (MAX_LINES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .lw_m1            (lw_m1),
    .fl_m1            (fl_m1),
    .scale            (scale_factor),
    .k_coef           (k_coefficient),
    .threshold        (corner_threshold),
    .tensor_xx        (tensor_xx),
    .tensor_xy        (tensor_xy),
    .tensor_yy        (tensor_yy),
    .frame_start      (frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pixel_response   (pixel_response),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_valid     (center_valid),
    .center_is_corner (center_is_corner),
    .frame_max        (frame_max),
    .frame_last       (frame_last)
  );

endmodule

FILE: sim/harris_response_nms_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harris_response_nms_tb
// Drives raster streams of structure-tensor pixels through the block in
// several register settings, predicts every result in a scoreboard with an
// exact wide-integer response model, line stores and a 3x3 window, and
// compares each transferred result field by field.
// ----------------------------------------------------------------------------
module harris_response_nms_tb;
  import hrn_pkg::*;

  typedef struct {
    logic signed [RESP_W-1:0] resp;
    logic [10:0]              cx;
    logic [10:0]              cy;
    logic                     cvalid;
    logic                     corner;
    logic [THR_W-1:0]         fmax;
    logic                     flast;
  } pixel_result_t;

  // Scoreboard: holds its own copy of the registers and the frame state,
  // predicts one result per transferred pixel and checks results in order.
  class harris_scoreboard;
    int errors;
    pixel_result_t expected_q[$];
    logic [11:0]        line_width;
    logic [11:0]        frame_lines;
    logic [23:0]        scale;
    logic [15:0]        k_coef;
    logic [THR_W-1:0]   threshold;
    logic signed [RESP_W-1:0] line_mem [0:4095];
    logic signed [RESP_W-1:0] win [0:2][0:2];
    int unsigned        col;
    int unsigned        row;
    logic [THR_W-1:0]   run_max;

    function new();
      errors = 0;
      line_width = 640;
      frame_lines = 480;
      scale = 72253;
      k_coef = 3932;
      threshold = 384000;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[r, c]) win[r][c] = '0;
      col = 0;
      row = 0;
      run_max = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_LINE_WIDTH:  line_width = v[11:0];
        REG_FRAME_LINES: frame_lines = v[11:0];
        REG_SCALE:       scale = v[23:0];
        REG_K:           k_coef = v[15:0];
        REG_THRESHOLD:   threshold = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact response: no intermediate ever leaves 200 bits, so plain
    // signed arithmetic gives the true value before rounding.
    function logic signed [RESP_W-1:0] response(logic [31:0] xx, logic signed [31:0] xy,
                                                logic [31:0] yy);
      logic signed [199:0] a, b, m, s, kk, sc, acc, sh;
      a = {168'd0, xx};
      b = {168'd0, yy};
      m = {{168{xy[31]}}, xy};
      if (m < 0) m = -m;
      s = a + b;
      kk = {184'd0, k_coef};
      sc = {176'd0, scale};
      acc = (a * b - m * m) * 200'sd65536 - kk * s * s;
      acc = acc * sc * sc + (200'sd1 <<< 55);
      sh = acc >>> 56;
      if (sh > 200'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
      if (sh < -200'sd140737488355328) return 48'h8000_0000_0000;
      return sh[RESP_W-1:0];
    endfunction

    function void note_pixel(logic [31:0] xx, logic signed [31:0] xy, logic [31:0] yy,
                             logic fs);
      int unsigned lw, fl, x, y, bank;
      logic signed [RESP_W-1:0] r, top, mid, ctr;
      pixel_result_t e;
      lw = line_width < 3 ? 3 : (line_width > 2048 ? 2048 : line_width);
      fl = frame_lines < 3 ? 3 : (frame_lines > 2048 ? 2048 : frame_lines);
      if (fs) begin
        col = 0;
        row = 0;
        run_max = '0;
      end
      x = col;
      y = row;
      r = response(xx, xy, yy);
      bank = y & 1;
      top = line_mem[bank * 2048 + x];
      mid = line_mem[(bank ^ 1) * 2048 + x];
      line_mem[bank * 2048 + x] = r;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = r;
      e.cvalid = 0;
      e.corner = 0;
      e.cx = '0;
      e.cy = '0;
      if (x >= 2 && y >= 2) begin
        e.cvalid = 1;
        e.cx = 11'(x - 1);
        e.cy = 11'(y - 1);
        ctr = win[1][1];
        e.corner = ctr > $signed({1'b0, threshold});
        foreach (win[i, j])
          if ((i != 1 || j != 1) && win[i][j] >= ctr) e.corner = 0;
      end
      if (r > 0 && r[THR_W-1:0] > run_max) run_max = r[THR_W-1:0];
      e.resp = r;
      e.fmax = run_max;
      e.flast = (x >= lw - 1) && (y >= fl - 1);
      expected_q.push_back(e);
      // advance the raster position; the frame end wraps like a frame start
      if (x >= lw - 1) begin
        col = 0;
        if (y >= fl - 1) begin
          row = 0;
          run_max = '0;
        end else begin
          row = y + 1;
        end
      end else begin
        col = x + 1;
      end
    endfunction

    function void check_result(pixel_result_t act);
      pixel_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, response %0d", $time, act.resp);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.resp !== e.resp) begin
        $display("%0t: pixel_response expected %0d actual %0d", $time, e.resp, act.resp);
        errors++;
      end
      if (act.cx !== e.cx) begin
        $display("%0t: center_x expected %0d actual %0d", $time, e.cx, act.cx);
        errors++;
      end
      if (act.cy !== e.cy) begin
        $display("%0t: center_y expected %0d actual %0d", $time, e.cy, act.cy);
        errors++;
      end
      if (act.cvalid !== e.cvalid) begin
        $display("%0t: center_valid expected %0b actual %0b", $time, e.cvalid, act.cvalid);
        errors++;
      end
      if (act.corner !== e.corner) begin
        $display("%0t: center_is_corner expected %0b actual %0b", $time, e.corner,
                 act.corner);
        errors++;
      end
      if (act.fmax !== e.fmax) begin
        $display("%0t: frame_max expected %0d actual %0d", $time, e.fmax, act.fmax);
        errors++;
      end
      if (act.flast !== e.flast) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, e.flast, act.flast);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     cfg_we = 0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic [31:0]              tensor_xx = '0;
  logic signed [31:0]       tensor_xy = '0;
  logic [31:0]              tensor_yy = '0;
  logic                     frame_start = 0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic signed [RESP_W-1:0] pixel_response;
  logic [10:0]              center_x;
  logic [10:0]              center_y;
  logic                     center_valid;
  logic                     center_is_corner;
  logic [THR_W-1:0]         frame_max;
  logic                     frame_last;

  harris_scoreboard sb = new();
  int stall_pct = 0;
  int stall_cycles = 0;

  harris_response_nms u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .tensor_xx        (tensor_xx),
    .tensor_xy        (tensor_xy),
    .tensor_yy        (tensor_yy),
    .frame_start      (frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pixel_response   (pixel_response),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_valid     (center_valid),
    .center_is_corner (center_is_corner),
    .frame_max        (frame_max),
    .frame_last       (frame_last)
  );

  always #10 clk = ~clk;

  // Receiver: check every result transfer, then pick the next ready level.
  // The stall rate is redrawn whenever its hold count runs out, zero among the choices.
  always @(posedge clk) begin
    pixel_result_t act;
    if (!rst && out_valid && out_ready) begin
      act.resp = pixel_response;
      act.cx = center_x;
      act.cy = center_y;
      act.cvalid = center_valid;
      act.corner = center_is_corner;
      act.fmax = frame_max;
      act.flast = frame_last;
      sb.check_result(act);
    end
    if (stall_cycles == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
      stall_cycles = $urandom_range(50, 400);
    end else begin
      stall_cycles--;
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hold valid and payload until the transfer, then note it in the scoreboard.
  task automatic send_pixel(logic [31:0] xx, logic signed [31:0] xy, logic [31:0] yy,
                            logic fs);
    in_valid <= 1;
    tensor_xx <= xx;
    tensor_xy <= xy;
    tensor_yy <= yy;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(xx, xy, yy, fs);
  endtask

  // Only called with the block idle; writes all five registers.
  task automatic configure(logic [11:0] lw, logic [11:0] fl, logic [23:0] sc,
                           logic [15:0] k, logic [THR_W-1:0] thr);
    logic [CFG_W-1:0] vals [5];
    logic [IDX_W-1:0] idx [5];
    vals = '{CFG_W'(lw), CFG_W'(fl), CFG_W'(sc), CFG_W'(k), CFG_W'(thr)};
    idx = '{REG_LINE_WIDTH, REG_FRAME_LINES, REG_SCALE, REG_K, REG_THRESHOLD};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Drop valid and hold until every expected result is back, plus the
  // block latency so nothing is still in flight.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mode 0: full 32-bit noise, 1: natural small tensors (often positive
  // responses, so corners appear), 2: extreme corner values
  task automatic make_pixel(int mode, output logic [31:0] xx, output logic signed [31:0] xy,
                            output logic [31:0] yy);
    logic [31:0] pick [4];
    pick = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1};
    case (mode)
      0: begin
        xx = $urandom;
        xy = $urandom;
        yy = $urandom;
      end
      1: begin
        xx = $urandom_range(0, 1 << 20);
        yy = $urandom_range(0, 1 << 20);
        xy = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      end
      default: begin
        xx = pick[$urandom_range(0, 3)];
        xy = pick[$urandom_range(0, 3)] ^ $urandom_range(0, 1);
        yy = pick[$urandom_range(0, 3)];
      end
    endcase
  endtask

  // One random phase: new registers, a frame start, then bursts of pixels.
  task automatic run_phase(logic [11:0] lw, logic [11:0] fl, logic [23:0] sc,
                           logic [15:0] k, logic [THR_W-1:0] thr, int count);
    logic [31:0] xx, yy;
    logic signed [31:0] xy;
    int burst;
    int mode;
    configure(lw, fl, sc, k, thr);
    burst = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 60);
      end
      mode = $urandom_range(0, 9);
      make_pixel(mode < 2 ? 0 : (mode < 9 ? 1 : 2), xx, xy, yy);
      send_pixel(xx, xy, yy, i == 0 || $urandom_range(0, 99) == 0);
      burst--;
    end
    drain();
  endtask

  initial begin
    logic [31:0] dxx [20], dyy [20];
    logic signed [31:0] dxy [20];
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zeros, full-scale diagonals, both xy extremes, an isolated
    // peak, and a restart of the frame in mid-line.
    dxx = '{0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 100, 100, 100, 100,
            100, 5000, 100, 100, 100, 100, 100, 1, 32'hFFFF_FFFF, 0, 7, 9};
    dyy = '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 100, 100, 100, 100,
            100, 5000, 100, 100, 100, 100, 100, 1, 0, 32'hFFFF_FFFF, 7, 9};
    dxy = '{0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0,
            0, 0, 0, 0, 0, 0, 0, -1, 32'sh8000_0000, 32'sh7FFF_FFFF, 3, -3};
    configure(4, 3, 72253, 3932, 384000);
    for (int i = 0; i < 20; i++)
      send_pixel(dxx[i], dxy[i], dyy[i], i == 0 || i == 14);
    drain();

    run_phase(5, 4, 72253, 3932, 0, 200);
    run_phase(0, 0, 24'hFF_FFFF, 0, 0, 100);
    run_phase(7, 5, 0, 16'hFFFF, 47'h7FFF_FFFF_FFFF, 100);
    run_phase(6, 3, 1000, 100, 5000, 200);
    run_phase(4095, 1, 65536, 3932, 1000, 500);
    run_phase(3, 4095, 300, 65535, 10, 80);
    run_phase(9, 6, 72253, 3932, 384000, 100);

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
src/hrn_pkg.sv
src/hrn_ctrl.sv
src/hrn_datapath.sv
src/harris_response_nms.sv
sim/harris_response_nms_tb.sv
